// ===== sv/bcb_pkg.sv =====
// ----------------------------------------------------------------------------
// bcb_pkg
// Types and constants shared by the bracket and comment balance checker.
// ----------------------------------------------------------------------------
package bcb_pkg;

  // Fixed widths of the result fields
  localparam int unsigned POS_W    = 24;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 3;

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

  // Bracket kind held in each stack cell
  typedef enum logic [1:0] {
    BR_ROUND  = 2'd0,
    BR_SQUARE = 2'd1,
    BR_CURLY  = 2'd2
  } br_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_BALANCED  = 3'd0,
    ST_MISMATCH  = 3'd1,
    ST_OPEN_LEFT = 3'd2,
    ST_UNCLOSED  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // Command from the controller to the row of stack cells
  typedef struct packed {
    logic push;
    logic pop;
    br_e  kind;
  } stk_cmd_t;

  // One result item
  typedef struct packed {
    status_e              status;
    logic [POS_W-1:0]     position;
    logic [POS_W-1:0]     comment_start;
    logic [DEPTH_W-1:0]   open_depth;
    logic [CHAR_W-1:0]    bad_char;
  } res_t;

endpackage

// ===== sv/bcb_cell.sv =====
// ----------------------------------------------------------------------------
// bcb_cell
// One stack cell: holds a bracket kind and shifts with its neighbours.
// ----------------------------------------------------------------------------
module bcb_cell
  import bcb_pkg::*;
(
  input  logic     clk_i,
  input  stk_cmd_t cmd_i,
  input  br_e      above_i,
  input  br_e      below_i,
  output br_e      kind_o
);

  br_e kind_q;
  br_e kind_d;

  // Take from above on push, from below on pop, else hold
  always_comb begin
    kind_d = kind_q;
    if (cmd_i.push) begin
      kind_d = above_i;
    end else if (cmd_i.pop) begin
      kind_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

// ===== sv/bcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcb_ctrl
// Scanner state, character count, stack level and result formation.
// ----------------------------------------------------------------------------
module bcb_ctrl
  import bcb_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [CHAR_W-1:0] ch_i,
  input  logic              last_i,
  input  br_e               top_i,
  output stk_cmd_t          cmd_o,
  output logic              res_valid_o,
  output res_t              res_o
);

  localparam int unsigned LVL_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CEXT_W  = COUNT_BITS + POS_W;
  localparam int unsigned LEXT_W  = LVL_W + DEPTH_W;

  logic                  in_comment_q, in_comment_d;
  logic                  star_q, star_d;
  logic                  slash_q, slash_d;
  logic                  failed_q, failed_d;
  logic                  ovf_q, ovf_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] origin_q, origin_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;

  logic                  blank;
  logic                  is_open;
  logic                  is_close;
  br_e                   kind;
  logic                  active;
  logic                  brk;
  logic                  mism;
  logic [CEXT_W-1:0]     cnt_ext;
  logic [CEXT_W-1:0]     origin_ext;
  logic [LEXT_W-1:0]     lvl_ext;

  // Classify the byte
  always_comb begin
    is_open  = 1'b0;
    is_close = 1'b0;
    kind     = BR_ROUND;
    unique case (ch_i)
      CH_LPAREN: begin is_open  = 1'b1; kind = BR_ROUND;  end
      CH_LBRACK: begin is_open  = 1'b1; kind = BR_SQUARE; end
      CH_LBRACE: begin is_open  = 1'b1; kind = BR_CURLY;  end
      CH_RPAREN: begin is_close = 1'b1; kind = BR_ROUND;  end
      CH_RBRACK: begin is_close = 1'b1; kind = BR_SQUARE; end
      CH_RBRACE: begin is_close = 1'b1; kind = BR_CURLY;  end
      default:   begin is_open  = 1'b0; end
    endcase
  end

  assign blank = (ch_i == CH_SPACE) || (ch_i == CH_TAB) || (ch_i == CH_LF) ||
                 (ch_i == CH_VT) || (ch_i == CH_FF) || (ch_i == CH_CR);

  assign active = accept_i && !failed_q && !ovf_q && !blank;

  // Next state, stack command and result
  always_comb begin
    in_comment_d = in_comment_q;
    star_d       = star_q;
    slash_d      = slash_q;
    failed_d     = failed_q;
    ovf_d        = ovf_q;
    cnt_d        = cnt_q;
    origin_d     = origin_q;
    lvl_d        = lvl_q;
    cmd_o        = '{push: 1'b0, pop: 1'b0, kind: kind};
    brk          = 1'b0;
    mism         = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (active) begin
      // Count non-blank bytes, saturating
      if (!(&cnt_q)) begin
        cnt_d = cnt_q + COUNT_BITS'(1);
      end

      if (in_comment_q) begin
        if (star_q && (ch_i == CH_SLASH)) begin
          in_comment_d = 1'b0;
          star_d       = 1'b0;
          origin_d     = '0;
        end else begin
          star_d = (ch_i == CH_STAR);
        end
      end else if (slash_q) begin
        if (ch_i == CH_STAR) begin
          slash_d      = 1'b0;
          in_comment_d = 1'b1;
          star_d       = 1'b0;
          origin_d     = cnt_d;
        end else if (ch_i != CH_SLASH) begin
          slash_d = 1'b0;
          brk     = 1'b1;
        end
      end else if (ch_i == CH_SLASH) begin
        slash_d = 1'b1;
      end else begin
        brk = 1'b1;
      end

      // Push or pop the bracket stack
      if (brk) begin
        if (is_open) begin
          if (lvl_q == LVL_W'(STACK_DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
            lvl_d      = lvl_q + LVL_W'(1);
          end
        end else if (is_close) begin
          if ((lvl_q != '0) && (top_i == kind)) begin
            cmd_o.pop = 1'b1;
            lvl_d     = lvl_q - LVL_W'(1);
          end else begin
            failed_d = 1'b1;
            mism     = 1'b1;
          end
        end
      end
    end

    cnt_ext    = CEXT_W'(cnt_d);
    origin_ext = CEXT_W'(origin_d);
    lvl_ext    = LEXT_W'(lvl_d);

    // Report a mismatched closer at once
    if (mism) begin
      res_valid_o      = 1'b1;
      res_o.status     = ST_MISMATCH;
      res_o.position   = cnt_ext[POS_W-1:0];
      res_o.open_depth = lvl_ext[DEPTH_W-1:0];
      res_o.bad_char   = ch_i;
    end

    // Final report unless the stream already failed, and return to the start state
    if (accept_i && last_i) begin
      if (!mism && !failed_q) begin
        res_valid_o      = 1'b1;
        res_o.position   = cnt_ext[POS_W-1:0];
        res_o.open_depth = lvl_ext[DEPTH_W-1:0];
        if (ovf_d) begin
          res_o.status = ST_OVERFLOW;
        end else if (in_comment_d) begin
          res_o.status        = ST_UNCLOSED;
          res_o.comment_start = origin_ext[POS_W-1:0];
        end else if (lvl_d != '0) begin
          res_o.status = ST_OPEN_LEFT;
        end else begin
          res_o.status = ST_BALANCED;
        end
      end
      in_comment_d = 1'b0;
      star_d       = 1'b0;
      slash_d      = 1'b0;
      failed_d     = 1'b0;
      ovf_d        = 1'b0;
      cnt_d        = '0;
      origin_d     = '0;
      lvl_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q <= 1'b0;
      star_q       <= 1'b0;
      slash_q      <= 1'b0;
      failed_q     <= 1'b0;
      ovf_q        <= 1'b0;
      cnt_q        <= '0;
      origin_q     <= '0;
      lvl_q        <= '0;
    end else begin
      in_comment_q <= in_comment_d;
      star_q       <= star_d;
      slash_q      <= slash_d;
      failed_q     <= failed_d;
      ovf_q        <= ovf_d;
      cnt_q        <= cnt_d;
      origin_q     <= origin_d;
      lvl_q        <= lvl_d;
    end
  end

endmodule

// ===== sv/bracket_and_comment_balance_checker.sv =====
// Output: a result item is registered and appears in the output register in the
//   cycle after the input item that causes it is accepted.
// Throughput: one item per cycle while the input is not stalled; the stack is a
//   row of shifting cells, so a push or pop completes in the cycle of its item.
// Reset: control state and counters clear at once; stack cells are not
//   cleared, the stack level alone marks which entries are live.
// ----------------------------------------------------------------------------
// bracket_and_comment_balance_checker
// Checks bracket nesting in a byte stream, skipping block comments.
// ----------------------------------------------------------------------------
module bracket_and_comment_balance_checker
  import bcb_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CHAR_W-1:0]   ch_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [POS_W-1:0]    position_o,
  output logic [POS_W-1:0]    comment_start_o,
  output logic [DEPTH_W-1:0]  open_depth_o,
  output logic [CHAR_W-1:0]   bad_char_o
);

  logic     accept;
  stk_cmd_t cmd;
  logic     res_valid;
  res_t     res;
  br_e      cell_kind [STACK_DEPTH];
  logic     out_valid_q, out_valid_d;
  res_t     res_q;

  // Stall input only while a held item cannot leave
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  bcb_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .top_i       (cell_kind[0]),
    .cmd_o       (cmd),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Row of stack cells, top of stack in cell zero
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    br_e above;
    br_e below;
    if (i == 0) begin : g_top
      assign above = cmd.kind;
    end else begin : g_mid
      assign above = cell_kind[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign below = cell_kind[i];
    end else begin : g_inner
      assign below = cell_kind[i+1];
    end
    bcb_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .above_i (above),
      .below_i (below),
      .kind_o  (cell_kind[i])
    );
  end

  // Output register: load a new item, drop a taken one
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign position_o      = res_q.position;
  assign comment_start_o = res_q.comment_start;
  assign open_depth_o    = res_q.open_depth;
  assign bad_char_o      = res_q.bad_char;

endmodule
